FILE: design/f2i8q_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// f2i8q_pkg
// types and constants shared by the float to int8 quantizer
// ---------------------------------------------------------------------------
package f2i8q_pkg;

    localparam int FRAC_BITS = 49;

    typedef struct packed {
        logic [31:0] value_bits;
        logic        last_in;
    } t_in_item;

    typedef struct packed {
        logic signed [7:0] qval;
        logic              last_out;
    } t_out_item;

    typedef enum logic [1:0] {
        REG_INV_SCALE  = 2'd0,
        REG_ZERO_POINT = 2'd1,
        REG_CLIP_LOW   = 2'd2,
        REG_CLIP_HIGH  = 2'd3
    } t_reg_idx;

    // early outcome of the product classification
    typedef enum logic [1:0] {
        CLS_NORMAL = 2'd0,
        CLS_ZERO   = 2'd1,
        CLS_Z      = 2'd2,
        CLS_SAT    = 2'd3
    } t_cls;

    function automatic logic [5:0] f_bitlen48(input logic [47:0] v);
        logic [5:0] n;
        n = '0;
        for (int i = 0; i < 48; i++) begin
            if (v[i]) begin
                n = 6'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

FILE: design/float_to_int8_affine_quantizer.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// float_to_int8_affine_quantizer
// fused zero_point + x*inv_scale, round to int, clamp to int8
// ---------------------------------------------------------------------------
// channel   | ports                                    | direction
// input     | i_start, o_busy, i_in                    | in
// result    | o_valid, o_out                           | out
// config    | psel penable pwrite paddr pwdata prdata  | in/out
//
// one item accepted every cycle; o_busy is always low
// each start transfer reaches o_valid through the register stages below
// five register stages: unpack, multiply, align/add, round, clamp
// synchronous active-low reset clears the valid chain and the config registers
// the receiver cannot stall, so nothing is held back
module float_to_int8_affine_quantizer
    import f2i8q_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  t_in_item    i_in,
    output logic        o_valid,
    output t_out_item   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [31:0] r_inv_scale;
    logic [7:0]  r_zp, r_lo, r_hi;
    t_reg_idx    w_idx;

    assign w_idx  = t_reg_idx'(paddr[3:2]);
    assign pready = 1'b1;
    assign o_busy = 1'b0;

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_scale <= 32'h3F80_0000;
            r_zp        <= 8'h00;
            r_lo        <= 8'h80;
            r_hi        <= 8'h7F;
        end else if (psel && penable && pwrite && pready) begin
            unique case (w_idx)
                REG_INV_SCALE:  r_inv_scale <= pwdata;
                REG_ZERO_POINT: r_zp        <= pwdata[7:0];
                REG_CLIP_LOW:   r_lo        <= pwdata[7:0];
                REG_CLIP_HIGH:  r_hi        <= pwdata[7:0];
                default:        ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_INV_SCALE:  prdata = r_inv_scale;
            REG_ZERO_POINT: prdata = {24'd0, r_zp};
            REG_CLIP_LOW:   prdata = {24'd0, r_lo};
            REG_CLIP_HIGH:  prdata = {24'd0, r_hi};
            default:        prdata = '0;
        endcase
    end

    f2i8q_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_start),
        .i_item      (i_in),
        .i_inv_scale (r_inv_scale),
        .i_zp        (r_zp),
        .i_lo        (r_lo),
        .i_hi        (r_hi),
        .o_valid     (o_valid),
        .o_item      (o_out)
    );

endmodule

FILE: design/f2i8q_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// f2i8q_core
// five-stage fused multiply-add, round and clamp datapath
// ---------------------------------------------------------------------------
module f2i8q_core
    import f2i8q_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_in_item    i_item,
    input  logic [31:0] i_inv_scale,
    input  logic [7:0]  i_zp,
    input  logic [7:0]  i_lo,
    input  logic [7:0]  i_hi,
    output logic        o_valid,
    output t_out_item   o_item
);

    // stage 1: unpack
    logic [4:0]  r_v;
    logic        r1_last, r1_neg, r1_nan, r1_inf, r1_zero;
    logic [23:0] r1_mx, r1_ms;
    logic signed [9:0] r1_e;

    logic [7:0] w_ex, w_es;
    logic       w_xz, w_sz;
    assign w_ex = i_item.value_bits[30:23];
    assign w_es = i_inv_scale[30:23];
    assign w_xz = (w_ex != 8'hFF) && (i_item.value_bits[30:0] == '0);
    assign w_sz = (w_es != 8'hFF) && (i_inv_scale[30:0] == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v <= '0;
        else          r_v <= {r_v[3:0], i_valid};
    end

    always_ff @(posedge i_clk) begin
        r1_last <= i_item.last_in;
        r1_neg  <= i_item.value_bits[31] ^ i_inv_scale[31];
        r1_nan  <= (w_ex == 8'hFF && i_item.value_bits[22:0] != '0)
                || (w_es == 8'hFF && i_inv_scale[22:0] != '0)
                || (w_ex == 8'hFF && w_sz) || (w_es == 8'hFF && w_xz);
        r1_inf  <= (w_ex == 8'hFF) || (w_es == 8'hFF);
        r1_zero <= w_xz || w_sz;
        r1_mx   <= {w_ex != 0, i_item.value_bits[22:0]};
        r1_ms   <= {w_es != 0, i_inv_scale[22:0]};
        r1_e    <= $signed({2'b00, (w_ex == 0) ? 8'd1 : w_ex})
                 + $signed({2'b00, (w_es == 0) ? 8'd1 : w_es}) - 10'sd300;
    end

    // stage 2: multiply
    logic        r2_last, r2_neg, r2_nan, r2_inf, r2_zero;
    logic [47:0] r2_m;
    logic signed [9:0] r2_e;
    always_ff @(posedge i_clk) begin
        r2_last <= r1_last; r2_neg <= r1_neg; r2_nan <= r1_nan;
        r2_inf  <= r1_inf;  r2_zero <= r1_zero; r2_e <= r1_e;
        r2_m    <= r1_mx * r1_ms;
    end

    // stage 3: classify, align to 2^-49 and add zero point
    logic [5:0]        w_len;
    logic signed [10:0] w_top, w_sh;
    t_cls              w_cls;
    logic [59:0]       w_mag;
    logic signed [61:0] w_sum;
    assign w_len = f_bitlen48(r2_m);
    assign w_top = 11'(r2_e) + 11'(w_len);
    assign w_sh  = 11'(r2_e) + 11'(FRAC_BITS);

    always_comb begin
        if (r2_nan)                          w_cls = CLS_ZERO;
        else if (r2_inf)                     w_cls = CLS_SAT;
        else if (r2_zero || r2_m == '0)      w_cls = CLS_Z;
        else if (w_top <= -11'sd2)           w_cls = CLS_Z;
        else if (w_top >= 11'sd11)           w_cls = CLS_SAT;
        else                                 w_cls = CLS_NORMAL;
        // shift stays within 0..58 for normal class
        if (w_sh >= 0) w_mag = 60'(r2_m) << w_sh[5:0];
        else           w_mag = 60'(r2_m) >> (-w_sh);
        w_sum = (r2_neg ? -$signed({2'b00, w_mag}) : $signed({2'b00, w_mag}))
              + ($signed({{54{i_zp[7]}}, i_zp}) <<< FRAC_BITS);
    end

    logic        r3_last, r3_neg;
    t_cls        r3_cls;
    logic [60:0] r3_a;
    logic signed [7:0] r3_zp;
    always_ff @(posedge i_clk) begin
        r3_last <= r2_last;
        r3_cls  <= w_cls;
        r3_neg  <= (w_cls == CLS_NORMAL) ? w_sum[61] : r2_neg;
        r3_a    <= w_sum[61] ? 61'(-w_sum) : 61'(w_sum);
        r3_zp   <= i_zp;
    end

    // stage 4: round to 24 bits then to integer
    logic [5:0]  w_bl;
    logic [60:0] w_low, w_half, w_r, w_rem;
    logic [11:0] w_q;
    logic [5:0]  w_d;
    logic signed [12:0] r4_int;
    logic        r4_last;
    always_comb begin
        w_bl = 6'd0;
        for (int i = 0; i < 61; i++) if (r3_a[i]) w_bl = 6'(i + 1);
        w_r = r3_a;
        if (w_bl > 6'd24) begin
            w_d    = w_bl - 6'd24;
            w_low  = r3_a & ((61'd1 << w_d) - 61'd1);
            w_half = 61'd1 << (w_d - 6'd1);
            w_r    = r3_a >> w_d;
            if (w_low > w_half || (w_low == w_half && w_r[0])) w_r = w_r + 61'd1;
            w_r = w_r << w_d;
        end else begin
            w_d = '0; w_low = '0; w_half = '0;
        end
        w_q   = w_r[60:49];
        w_rem = {12'd0, w_r[48:0]};
        if (w_rem > (61'd1 << 48) || (w_rem == (61'd1 << 48) && w_q[0]))
            w_q = w_q + 12'd1;
    end

    // magnitude can reach 1152, so the whole quotient is kept
    always_ff @(posedge i_clk) begin
        r4_last <= r3_last;
        unique case (r3_cls)
            CLS_ZERO: r4_int <= '0;
            CLS_Z:    r4_int <= 13'(r3_zp);
            CLS_SAT:  r4_int <= r3_neg ? -13'sd4096 : 13'sd4095;
            default:  r4_int <= r3_neg ? -$signed({1'b0, w_q})
                                       : $signed({1'b0, w_q});
        endcase
    end

    // stage 5: clamp, low first then high
    logic signed [12:0] w_c;
    always_comb begin
        w_c = r4_int;
        if (w_c < 13'($signed(i_lo))) w_c = 13'($signed(i_lo));
        if (w_c > 13'($signed(i_hi))) w_c = 13'($signed(i_hi));
    end

    always_ff @(posedge i_clk) begin
        o_item.qval     <= w_c[7:0];
        o_item.last_out <= r4_last;
    end
    assign o_valid = r_v[4];

endmodule

FILE: tb/f2i8q_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// f2i8q_checker
// follows the register writes and the input transfers, predicts each int8
// code and compares it with the result stream in order
// ---------------------------------------------------------------------------
module f2i8q_checker
    import f2i8q_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  t_in_item    i_in,
    input  logic        i_valid,
    input  t_out_item   i_out,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [3:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic        i_pready,
    output int          o_fail_count,
    output int          o_pending
);

    typedef enum int {K_FIN, K_INF, K_NAN} t_kind;

    logic [31:0]       scale_bits;
    logic signed [7:0] zp_reg;
    logic signed [7:0] lo_reg;
    logic signed [7:0] hi_reg;
    t_out_item         pending_codes[$];
    int                fails;

    function automatic int bit_len(input logic [63:0] v);
        int n;
        n = 0;
        for (int i = 0; i < 64; i++) begin
            if (v[i]) begin
                n = i + 1;
            end
        end
        return n;
    endfunction

    function automatic void split_float(input logic [31:0] b, output t_kind k,
                                        output logic [63:0] sig, output int ex);
        k = K_FIN;
        sig = '0;
        ex = 0;
        if (b[30:23] == 8'hFF) begin
            k = (b[22:0] != 0) ? K_NAN : K_INF;
        end else if (b[30:23] == 8'h00) begin
            sig = {41'd0, b[22:0]};
            ex = -149;
        end else begin
            sig = {40'd0, 1'b1, b[22:0]};
            ex = int'(b[30:23]) - 150;
        end
    endfunction

    // z + x*s rounded once to single precision, then to int32 ties to even
    function automatic int fused_int(input logic [31:0] x, input logic [31:0] s,
                                     input int z);
        t_kind       kx, ks;
        logic [63:0] mx, ms, m, a, q, rem, low, half;
        int          ex, es, e, len, blen, d;
        logic        neg;
        longint      v;
        split_float(x, kx, mx, ex);
        split_float(s, ks, ms, es);
        neg = x[31] ^ s[31];
        if (kx == K_NAN || ks == K_NAN) begin
            return 0;
        end
        if (kx == K_INF || ks == K_INF) begin
            if ((kx == K_FIN && mx == 0) || (ks == K_FIN && ms == 0)) begin
                return 0;
            end
            return neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        m = mx * ms;
        if (m == 0) begin
            return z;
        end
        e = ex + es;
        len = bit_len(m);
        if (len + e <= -2) begin
            return z;
        end
        if (len - 1 + e >= 10) begin
            return neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        v = longint'(m << (e + FRAC_BITS));
        if (neg) begin
            v = -v;
        end
        v = v + longint'(z) * (64'sd1 <<< FRAC_BITS);
        if (v == 0) begin
            return 0;
        end
        neg = v < 0;
        a = neg ? 64'(-v) : 64'(v);
        blen = bit_len(a);
        if (blen > 24) begin
            d = blen - 24;
            low = a & ((64'd1 << d) - 64'd1);
            half = 64'd1 << (d - 1);
            a = a >> d;
            if (low > half || (low == half && a[0])) begin
                a = a + 64'd1;
            end
            a = a << d;
        end
        q = a >> FRAC_BITS;
        rem = a & ((64'd1 << FRAC_BITS) - 64'd1);
        half = 64'd1 << (FRAC_BITS - 1);
        if (rem > half || (rem == half && q[0])) begin
            q = q + 64'd1;
        end
        return neg ? -int'(q) : int'(q);
    endfunction

    function automatic t_out_item quantize_value(input t_in_item it);
        t_out_item r;
        int        val;
        val = fused_int(it.value_bits, scale_bits, int'(zp_reg));
        // raise to the low bound first, so a crossed range ends on the high bound
        if (val < int'(lo_reg)) begin
            val = int'(lo_reg);
        end
        if (val > int'(hi_reg)) begin
            val = int'(hi_reg);
        end
        r.qval = val[7:0];
        r.last_out = it.last_in;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            scale_bits <= 32'h3F80_0000;
            zp_reg <= 8'sd0;
            lo_reg <= -8'sd128;
            hi_reg <= 8'sd127;
        end else begin
            if (i_valid) begin
                if (pending_codes.size() == 0) begin
                    $display("%0t: unexpected result qval=%0d last=%0b",
                             $time, i_out.qval, i_out.last_out);
                    fails++;
                end else begin
                    want = pending_codes.pop_front();
                    if (want.qval !== i_out.qval) begin
                        $display("%0t: qval expected %0d actual %0d",
                                 $time, want.qval, i_out.qval);
                        fails++;
                    end
                    if (want.last_out !== i_out.last_out) begin
                        $display("%0t: last_out expected %0b actual %0b",
                                 $time, want.last_out, i_out.last_out);
                        fails++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                pending_codes.push_back(quantize_value(i_in));
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[3:2]))
                    REG_INV_SCALE:  scale_bits <= i_pwdata;
                    REG_ZERO_POINT: zp_reg <= i_pwdata[7:0];
                    REG_CLIP_LOW:   lo_reg <= i_pwdata[7:0];
                    REG_CLIP_HIGH:  hi_reg <= i_pwdata[7:0];
                    default: ;
                endcase
            end
        end
    end

    initial fails = 0;
    assign o_fail_count = fails;
    assign o_pending = pending_codes.size();

endmodule

FILE: tb/float_to_int8_affine_quantizer_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// float_to_int8_affine_quantizer_tb
// drives float items and register writes into the quantizer; a checker
// beside the block predicts every int8 code and reports the mismatches
// ---------------------------------------------------------------------------
module float_to_int8_affine_quantizer_tb;
    import f2i8q_pkg::*;

    localparam int N_PHASES = 12;
    localparam int RAND_PER_PHASE = 62;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    t_in_item    i_in;
    logic        o_valid;
    t_out_item   o_out;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;
    logic        burst_mode;   // phase with no gaps between transfers

    // corner values: zeros, infinities, nans, denormals, ties and clip edges
    logic [31:0] corner_vals[20] = '{
        32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
        32'h7FC0_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h807F_FFFF,
        32'h3F80_0000, 32'h3F00_0000, 32'h3FC0_0000, 32'h4020_0000,
        32'hC020_0000, 32'h42FF_0000, 32'h4300_0000, 32'hC301_0000,
        32'h7F7F_FFFF, 32'h3E80_0000, 32'h3E80_0001, 32'h3EFF_FFFF
    };

    float_to_int8_affine_quantizer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .o_busy  (o_busy),
        .i_in    (i_in),
        .o_valid (o_valid),
        .o_out   (o_out),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    f2i8q_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .i_busy       (o_busy),
        .i_in         (i_in),
        .i_valid      (o_valid),
        .i_out        (o_out),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst_mode || r < 50) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // mostly values near the int8 range, plus fully random bits and corners
    function automatic logic [31:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return $urandom;
        end else if (r == 1) begin
            return corner_vals[$urandom_range(0, 19)];
        end
        return {1'($urandom), 8'($urandom_range(8'h70, 8'h88)), 23'($urandom)};
    endfunction

    // setup cycle then access cycle; the write lands when pready is seen high
    task automatic reg_write(input t_reg_idx idx, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic write_all(input logic [31:0] scale, input logic [7:0] zp,
                             input logic [7:0] lo, input logic [7:0] hi);
        reg_write(REG_INV_SCALE, scale);
        reg_write(REG_ZERO_POINT, {24'd0, zp});
        reg_write(REG_CLIP_LOW, {24'd0, lo});
        reg_write(REG_CLIP_HIGH, {24'd0, hi});
    endtask

    // one input transfer, then an optional gap with start low
    task automatic send_item(input logic [31:0] bits, input logic last);
        int gap;
        i_in <= '{value_bits: bits, last_in: last};
        i_start <= 1'b1;
        do @(posedge i_clk); while (o_busy);
        gap = pick_gap();
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // let the pipeline drain before touching the registers again
    task automatic drain();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    initial begin
        logic [7:0] a, b;
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_in = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        burst_mode = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int p = 0; p < N_PHASES; p++) begin
            a = 8'($urandom_range(0, 255));
            b = 8'($urandom_range(0, 255));
            case (p)
                0: ;   // reset settings
                1: write_all(32'h7F7F_FFFF, 8'h7F, 8'h80, 8'h7F);
                2: write_all(32'h0000_0000, 8'h80, 8'h80, 8'h7F);
                3: write_all(32'h7F80_0000, 8'h05, 8'hF0, 8'h10);
                // crossed clip range with a nan scale
                4: write_all(32'h7FC0_0001, a, 8'd100, 8'h9C);
                5: write_all(32'h0000_0001, a, 8'h80, 8'h7F);
                6: write_all(32'hBF00_0000, a, 8'h80, 8'h7F);
                7: write_all(32'hFFFF_FFFF, 8'h80, 8'h7F, 8'h80);
                default: begin
                    write_all({1'($urandom), 8'($urandom_range(8'h78, 8'h88)),
                               23'($urandom)}, a,
                              ($signed(a) < $signed(b)) ? a : b,
                              ($signed(a) < $signed(b)) ? b : a);
                end
            endcase
            burst_mode = ($urandom_range(0, 3) == 0);
            if (p == 0 || p == 6) begin
                foreach (corner_vals[k]) begin
                    send_item(corner_vals[k], 1'(k));
                end
            end
            for (int k = 0; k < RAND_PER_PHASE; k++) begin
                send_item(pick_value(), 1'($urandom));
            end
            drain();
        end

        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("status: fail");
        $finish;
    end

endmodule
